[hdl/dbfr_pkg.sv]
package dbfr_pkg;

  localparam int ROW_BITS    = 6;
  localparam int COL_BITS    = 6;
  localparam int CELL_BITS   = ROW_BITS + COL_BITS;
  localparam int DIM_BITS    = 7;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int HEIGHT_BITS = 16;
  localparam int DEPTH_BITS  = CELL_BITS + 1;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [1:0] NB_DOWN  = 2'd0;
  localparam logic [1:0] NB_UP    = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_LEFT  = 2'd3;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_CLR     = 12'b000000000010,
    ST_SEED_RD = 12'b000000000100,
    ST_SEED_MK = 12'b000000001000,
    ST_POP     = 12'b000000010000,
    ST_CUR     = 12'b000000100000,
    ST_CURH    = 12'b000001000000,
    ST_NB      = 12'b000010000000,
    ST_NBCHK   = 12'b000100000000,
    ST_OUT_RD0 = 12'b001000000000,
    ST_OUT_RD1 = 12'b010000000000,
    ST_OUT_CAP = 12'b100000000000
  } state_t;

  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v,
                                                  input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

[hdl/dbfr_ram.sv]
module dbfr_ram #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/dual_border_flood_reachability.sv]
// Load: one cycle per height word while busy is low; the last cell of the grid raises busy.
// Solve: clearing pass over all 128 reach-map words, then per fill its edge seeds, then each
// popped cell's neighbours, pushing unreached in-range ones no lower, until the stack empties.
// Output: one result word per row; strobe high for one cycle, never stalled.
// Reset (rst_n low, synchronous): idle, load position zero, row_count and col_count 64.
module dual_border_flood_reachability (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_height,
  output logic        out_strobe,
  output logic [5:0]  out_row_index,
  output logic [63:0] out_both_mask,
  output logic        out_last_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RB = dbfr_pkg::ROW_BITS;
  localparam int CB = dbfr_pkg::COL_BITS;
  localparam int XB = dbfr_pkg::CELL_BITS;
  localparam int DB = dbfr_pkg::DIM_BITS;
  localparam int HB = dbfr_pkg::HEIGHT_BITS;
  localparam int SB = dbfr_pkg::DEPTH_BITS;
  localparam int MW = dbfr_pkg::MAX_COLS;

  dbfr_pkg::state_t state_r, state_nxt;

  logic [DB-1:0] row_cfg_r, col_cfg_r;
  logic [DB-1:0] rows_e, cols_e;
  logic [RB-1:0] lr_r, lr_nxt;
  logic [CB-1:0] lc_r, lc_nxt;
  logic [RB:0]   clr_r, clr_nxt;
  logic          fsel_r, fsel_nxt;
  logic          sph_r, sph_nxt;
  logic [DB-1:0] sc_r, sc_nxt;
  logic [SB-1:0] sd_r, sd_nxt;
  logic [RB-1:0] cr_r, cr_nxt, tr_r, tr_nxt, or_r, or_nxt;
  logic [CB-1:0] cc_r, cc_nxt, tc_r, tc_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [HB-1:0] hc_r, hc_nxt;
  logic [MW-1:0] a_r, a_nxt;

  logic          h_we;
  logic [XB-1:0] h_waddr, h_raddr;
  logic [HB-1:0] h_q;
  logic          m_we;
  logic [RB:0]   m_waddr, m_raddr;
  logic [MW-1:0] m_wdata, m_q;
  logic          s_we;
  logic [XB-1:0] s_raddr;
  logic [XB-1:0] s_q;

  logic          cfg_we, accept;
  logic [DB-1:0] nbr, nbc, sdr, sdc;
  logic          nbok, bit_set;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign busy   = (state_r != dbfr_pkg::ST_IDLE);
  assign accept = start & ~busy;
  assign rows_e = dbfr_pkg::eff_dim(row_cfg_r, DB'(dbfr_pkg::MAX_ROWS));
  assign cols_e = dbfr_pkg::eff_dim(col_cfg_r, DB'(dbfr_pkg::MAX_COLS));
  assign prdata = (paddr[2] == dbfr_pkg::REG_COL_COUNT) ? {25'd0, col_cfg_r} : {25'd0, row_cfg_r};
  assign bit_set = m_q[tc_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cfg_r <= DB'(dbfr_pkg::MAX_ROWS);
      col_cfg_r <= DB'(dbfr_pkg::MAX_COLS);
    end else if (cfg_we) begin
      if (paddr[2] == dbfr_pkg::REG_ROW_COUNT) row_cfg_r <= pwdata[DB-1:0];
      else row_cfg_r <= row_cfg_r;
      if (paddr[2] == dbfr_pkg::REG_COL_COUNT) col_cfg_r <= pwdata[DB-1:0];
      else col_cfg_r <= col_cfg_r;
    end
  end

  always_comb begin
    nbr  = {1'b0, cr_r};
    nbc  = {1'b0, cc_r};
    nbok = 1'b0;
    case (k_r)
      dbfr_pkg::NB_DOWN: begin
        nbr  = {1'b0, cr_r} + DB'(1);
        nbok = nbr < rows_e;
      end
      dbfr_pkg::NB_UP: begin
        nbr  = {1'b0, cr_r} - DB'(1);
        nbok = cr_r != '0;
      end
      dbfr_pkg::NB_RIGHT: begin
        nbc  = {1'b0, cc_r} + DB'(1);
        nbok = nbc < cols_e;
      end
      dbfr_pkg::NB_LEFT: begin
        nbc  = {1'b0, cc_r} - DB'(1);
        nbok = cc_r != '0;
      end
      default: nbok = 1'b0;
    endcase
  end

  always_comb begin
    if (!sph_r) begin
      sdr = sc_r;
      sdc = fsel_r ? cols_e - DB'(1) : '0;
    end else begin
      sdr = fsel_r ? rows_e - DB'(1) : '0;
      sdc = sc_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lr_nxt = lr_r; lc_nxt = lc_r; clr_nxt = clr_r;
    fsel_nxt = fsel_r; sph_nxt = sph_r; sc_nxt = sc_r; sd_nxt = sd_r;
    cr_nxt = cr_r; cc_nxt = cc_r; tr_nxt = tr_r; tc_nxt = tc_r;
    k_nxt = k_r; hc_nxt = hc_r; or_nxt = or_r; a_nxt = a_r;
    h_we = 1'b0; h_waddr = {lr_r, lc_r}; h_raddr = {nbr[RB-1:0], nbc[CB-1:0]};
    m_we = 1'b0; m_waddr = {fsel_r, tr_r}; m_wdata = m_q | (MW'(1) << tc_r);
    m_raddr = {fsel_r, nbr[RB-1:0]};
    s_we = 1'b0; s_raddr = s_q;
    s_raddr = XB'(sd_r - SB'(1));
    case (state_r)
      dbfr_pkg::ST_IDLE: begin
        if (accept) begin
          h_we = 1'b1;
          if ({1'b0, lc_r} == cols_e - DB'(1)) begin
            lc_nxt = '0;
            if ({1'b0, lr_r} == rows_e - DB'(1)) begin
              lr_nxt    = '0;
              clr_nxt   = '0;
              state_nxt = dbfr_pkg::ST_CLR;
            end else begin
              lr_nxt = lr_r + RB'(1);
            end
          end else begin
            lc_nxt = lc_r + CB'(1);
          end
        end
        if (cfg_we) begin
          lr_nxt = '0;
          lc_nxt = '0;
        end
      end
      dbfr_pkg::ST_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
        clr_nxt = clr_r + (RB+1)'(1);
        if (clr_r == '1) begin
          fsel_nxt  = 1'b0;
          sph_nxt   = 1'b0;
          sc_nxt    = '0;
          sd_nxt    = '0;
          state_nxt = dbfr_pkg::ST_SEED_RD;
        end
      end
      dbfr_pkg::ST_SEED_RD: begin
        m_raddr   = {fsel_r, sdr[RB-1:0]};
        tr_nxt    = sdr[RB-1:0];
        tc_nxt    = sdc[CB-1:0];
        state_nxt = dbfr_pkg::ST_SEED_MK;
      end
      dbfr_pkg::ST_SEED_MK: begin
        if (!bit_set) begin
          m_we   = 1'b1;
          s_we   = 1'b1;
          sd_nxt = sd_r + SB'(1);
        end
        sc_nxt    = sc_r + DB'(1);
        state_nxt = dbfr_pkg::ST_SEED_RD;
        if (!sph_r && sc_r == rows_e - DB'(1)) begin
          sph_nxt = 1'b1;
          sc_nxt  = '0;
        end else if (sph_r && sc_r == cols_e - DB'(1)) begin
          state_nxt = dbfr_pkg::ST_POP;
        end
      end
      dbfr_pkg::ST_POP: begin
        if (sd_r == '0) begin
          if (!fsel_r) begin
            fsel_nxt  = 1'b1;
            sph_nxt   = 1'b0;
            sc_nxt    = '0;
            state_nxt = dbfr_pkg::ST_SEED_RD;
          end else begin
            or_nxt    = '0;
            state_nxt = dbfr_pkg::ST_OUT_RD0;
          end
        end else begin
          sd_nxt    = sd_r - SB'(1);
          state_nxt = dbfr_pkg::ST_CUR;
        end
      end
      dbfr_pkg::ST_CUR: begin
        h_raddr   = s_q;
        cr_nxt    = s_q[XB-1:CB];
        cc_nxt    = s_q[CB-1:0];
        state_nxt = dbfr_pkg::ST_CURH;
      end
      dbfr_pkg::ST_CURH: begin
        hc_nxt    = h_q;
        k_nxt     = dbfr_pkg::NB_DOWN;
        state_nxt = dbfr_pkg::ST_NB;
      end
      dbfr_pkg::ST_NB: begin
        tr_nxt = nbr[RB-1:0];
        tc_nxt = nbc[CB-1:0];
        if (nbok) begin
          state_nxt = dbfr_pkg::ST_NBCHK;
        end else if (k_r == dbfr_pkg::NB_LEFT) begin
          state_nxt = dbfr_pkg::ST_POP;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      dbfr_pkg::ST_NBCHK: begin
        if (!bit_set && h_q >= hc_r) begin
          m_we   = 1'b1;
          s_we   = 1'b1;
          sd_nxt = sd_r + SB'(1);
        end
        if (k_r == dbfr_pkg::NB_LEFT) begin
          state_nxt = dbfr_pkg::ST_POP;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = dbfr_pkg::ST_NB;
        end
      end
      dbfr_pkg::ST_OUT_RD0: begin
        m_raddr   = {1'b0, or_r};
        state_nxt = dbfr_pkg::ST_OUT_RD1;
      end
      dbfr_pkg::ST_OUT_RD1: begin
        m_raddr   = {1'b1, or_r};
        a_nxt     = m_q;
        state_nxt = dbfr_pkg::ST_OUT_CAP;
      end
      dbfr_pkg::ST_OUT_CAP: begin
        or_nxt = or_r + RB'(1);
        if ({1'b0, or_r} == rows_e - DB'(1)) state_nxt = dbfr_pkg::ST_IDLE;
        else state_nxt = dbfr_pkg::ST_OUT_RD0;
      end
      default: state_nxt = dbfr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dbfr_pkg::ST_IDLE;
      lr_r       <= '0;
      lc_r       <= '0;
      sd_r       <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lr_r       <= lr_nxt;
      lc_r       <= lc_nxt;
      sd_r       <= sd_nxt;
      out_strobe <= (state_r == dbfr_pkg::ST_OUT_CAP);
    end
  end

  always_ff @(posedge clk) begin
    clr_r  <= clr_nxt;
    fsel_r <= fsel_nxt;
    sph_r  <= sph_nxt;
    sc_r   <= sc_nxt;
    cr_r   <= cr_nxt;
    cc_r   <= cc_nxt;
    tr_r   <= tr_nxt;
    tc_r   <= tc_nxt;
    k_r    <= k_nxt;
    hc_r   <= hc_nxt;
    or_r   <= or_nxt;
    a_r    <= a_nxt;
    if (state_r == dbfr_pkg::ST_OUT_CAP) begin
      out_row_index <= or_r;
      out_both_mask <= a_r & m_q;
      out_last_row  <= ({1'b0, or_r} == rows_e - DB'(1));
    end
  end

  dbfr_ram #(.AW(XB), .DW(HB)) u_height (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(in_height[HB-1:0]),
    .raddr(h_raddr), .rdata(h_q)
  );

  dbfr_ram #(.AW(RB + 1), .DW(MW)) u_reach (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_q)
  );

  dbfr_ram #(.AW(XB), .DW(XB)) u_stack (
    .clk(clk), .we(s_we), .waddr(sd_r[XB-1:0]), .wdata({tr_r, tc_r}),
    .raddr(s_raddr), .rdata(s_q)
  );

endmodule
